FILE: design/lane_boundary_row_scanner_top_assert.svh
// Assertion macros used by the lane boundary row scanner checker.
// Both macros expect clk and rst_n in the scope of use.
`ifndef LANE_BOUNDARY_ROW_SCANNER_TOP_ASSERT_SVH
`define LANE_BOUNDARY_ROW_SCANNER_TOP_ASSERT_SVH

// same-cycle implication
`define LBRS_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lane boundary row scanner check failed");

// next-cycle implication
`define LBRS_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lane boundary row scanner check failed");

`endif

FILE: design/lbrs_pkg.sv
// Shared types and constants of the lane boundary row scanner.
// No dependencies; every design module imports this package.
package lbrs_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_ROWS_DEF  = 64;

    localparam int IW_W   = 11;
    localparam int ST_W   = 7;
    localparam int BT_W   = 7;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam int              IMAGE_WIDTH_RST   = 640;
    localparam logic [ST_W-1:0] SAMPLE_TARGET_RST = 7'd11;
    localparam logic [BT_W-1:0] BORDER_THRESH_RST = 7'd3;

    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_SAMPLE_TARGET = 2'd1;
    localparam logic [1:0] REG_BORDER_THRESH = 2'd2;

    typedef enum logic [1:0] {
        MODE_LOSE       = 2'd0,
        MODE_OBSTACLE   = 2'd1,
        MODE_FORWARD    = 2'd2,
        MODE_HORIZONTAL = 2'd3
    } drive_mode_t;

    typedef struct packed {
        logic [IW_W-1:0] image_width;
        logic [ST_W-1:0] sample_target;
        logic [BT_W-1:0] border_thresh;
    } cfg_t;

    typedef enum logic [1:0] {
        SC_LOAD,
        SC_STEP,
        SC_EVAL,
        SC_FIN
    } scan_state_t;

    typedef enum logic [3:0] {
        PH_SEED,
        PH_ZERO,
        PH_LAST,
        PH_A_LEFT,
        PH_A_RIGHT,
        PH_B_FIND,
        PH_B_RUN,
        PH_C_FIND,
        PH_C_LEFT
    } scan_phase_t;

    typedef struct packed {
        logic found;
        logic hit_left;
        logic hit_right;
        logic frame_end;
    } scan_flags_t;

endpackage

FILE: design/lane_boundary_row_scanner_top.sv
// Lane boundary row scanner. Pixels of a sampled row are taken one per cycle
// into a row buffer. The item that carries row_end starts the edge search and
// holds in_ready low until it is done and its result is taken: the search
// reads the W buffered columns, W being image_width clamped to 2..MAX_WIDTH,
// one at a time through its single read port, a step and an evaluate state
// per column, ending early when the lane sits near the seed column. One result
// per row comes out of a result register, which frees the input side while
// the result waits. No clearing pass is run after reset.
// Depends on lbrs_pkg, lbrs_regs, lbrs_scan and lbrs_frame.
module lane_boundary_row_scanner_top #(
    parameter int MAX_WIDTH = lbrs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_ROWS  = lbrs_pkg::MAX_ROWS_DEF,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int XW = AW + 1,
    localparam int CW = $clog2(MAX_ROWS + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lbrs_pkg::APB_AW-1:0] paddr,
    input  logic [lbrs_pkg::APB_DW-1:0] pwdata,
    output logic [lbrs_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        pixel,
    input  logic                        row_end,
    input  logic                        frame_end,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [XW-1:0]               left_x,
    output logic [XW-1:0]               right_x,
    output logic [AW-1:0]               mid_x,
    output logic                        row_found,
    output logic                        frame_done,
    output logic [1:0]                  drive_mode,
    output logic                        left_is_border,
    output logic                        right_is_border,
    output logic [CW-1:0]               rows_counted
);
    import lbrs_pkg::*;

    cfg_t          cfg;
    logic [XW-1:0] col;
    logic [AW-1:0] seed;
    logic          res_valid;
    logic          res_ready;
    logic [XW-1:0] scan_left;
    logic [XW-1:0] scan_right;
    scan_flags_t   scan_flags;

    lbrs_regs #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .col     (col)
    );

    lbrs_scan #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel     (pixel),
        .row_end   (row_end),
        .frame_end (frame_end),
        .col       (col),
        .seed      (seed),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .left      (scan_left),
        .right     (scan_right),
        .flags     (scan_flags)
    );

    lbrs_frame #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_ROWS (MAX_ROWS)
    ) u_frame (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .col             (col),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .left            (scan_left),
        .right           (scan_right),
        .flags           (scan_flags),
        .seed            (seed),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .left_x          (left_x),
        .right_x         (right_x),
        .mid_x           (mid_x),
        .row_found       (row_found),
        .frame_done      (frame_done),
        .drive_mode      (drive_mode),
        .left_is_border  (left_is_border),
        .right_is_border (right_is_border),
        .rows_counted    (rows_counted)
    );

endmodule

FILE: design/lbrs_regs.sv
// APB configuration registers and the clamped column count.
// Depends on lbrs_pkg.
module lbrs_regs #(
    parameter int MAX_WIDTH = lbrs_pkg::MAX_WIDTH_DEF,
    localparam int XW = $clog2(MAX_WIDTH) + 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lbrs_pkg::APB_AW-1:0] paddr,
    input  logic [lbrs_pkg::APB_DW-1:0] pwdata,
    output logic [lbrs_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output lbrs_pkg::cfg_t             cfg,
    output logic [XW-1:0]              col
);
    import lbrs_pkg::*;

    localparam int WW = (XW > IW_W) ? XW : IW_W;

    cfg_t          cfg_reg;
    logic [1:0]    reg_sel;
    logic          wr_en;
    logic [WW-1:0] iw_ext;
    logic [WW-1:0] col_wide;

    assign pready  = 1'b1;
    assign reg_sel = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width   <= IW_W'(IMAGE_WIDTH_RST);
            cfg_reg.sample_target <= SAMPLE_TARGET_RST;
            cfg_reg.border_thresh <= BORDER_THRESH_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_IMAGE_WIDTH:   cfg_reg.image_width   <= pwdata[IW_W-1:0];
                REG_SAMPLE_TARGET: cfg_reg.sample_target <= pwdata[ST_W-1:0];
                REG_BORDER_THRESH: cfg_reg.border_thresh <= pwdata[BT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_IMAGE_WIDTH:   prdata = APB_DW'(cfg_reg.image_width);
            REG_SAMPLE_TARGET: prdata = APB_DW'(cfg_reg.sample_target);
            REG_BORDER_THRESH: prdata = APB_DW'(cfg_reg.border_thresh);
            default:           prdata = '0;
        endcase
    end

    // clamp the width in use to 2..MAX_WIDTH
    always_comb
    begin
        iw_ext = WW'(cfg_reg.image_width);
        if (iw_ext < WW'(2))
            col_wide = WW'(2);
        else if (iw_ext > WW'(MAX_WIDTH))
            col_wide = WW'(MAX_WIDTH);
        else
            col_wide = iw_ext;
    end

    assign col = col_wide[XW-1:0];
    assign cfg = cfg_reg;

endmodule

FILE: design/lbrs_scan.sv
// Row buffer and edge search sequencer: one buffer read and one compare per step.
// Depends on lbrs_pkg.
module lbrs_scan #(
    parameter int MAX_WIDTH = lbrs_pkg::MAX_WIDTH_DEF,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int XW = AW + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  pixel,
    input  logic                  row_end,
    input  logic                  frame_end,
    input  logic [XW-1:0]         col,
    input  logic [AW-1:0]         seed,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [XW-1:0]         left,
    output logic [XW-1:0]         right,
    output lbrs_pkg::scan_flags_t flags
);
    import lbrs_pkg::*;

    logic row_mem [MAX_WIDTH];

    scan_state_t state_reg, state_next;
    scan_phase_t phase_reg, phase_next;
    logic [XW-1:0] pos_reg, pos_next;
    logic [XW-1:0] left_reg, left_next;
    logic [XW-1:0] right_reg, right_next;
    logic [XW-1:0] pix_idx_reg, pix_idx_next;
    scan_flags_t   flags_reg, flags_next;
    logic          rd_bit_reg;

    logic          accept;
    logic [XW-1:0] seed_ext;
    logic [XW-1:0] x0;
    logic          at_zero;
    logic          at_col;
    logic          stop_bound;
    logic          eval_finish;
    logic          rd_en;

    assign in_ready = (state_reg == SC_LOAD);
    assign accept   = in_valid && in_ready;
    assign seed_ext = XW'(seed);
    assign x0       = (seed_ext >= col) ? col - 1'b1 : seed_ext;
    assign at_zero  = (pos_reg == '0);
    assign at_col   = (pos_reg == col);
    assign rd_en    = (state_reg == SC_STEP) && !stop_bound;

    always_comb
    begin
        unique case (phase_reg) inside
            PH_A_LEFT, PH_C_LEFT, PH_C_FIND: stop_bound = at_zero;
            PH_A_RIGHT, PH_B_FIND, PH_B_RUN: stop_bound = at_col;
            default:                         stop_bound = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (phase_reg) inside
            PH_A_RIGHT, PH_B_RUN, PH_C_LEFT: eval_finish = !rd_bit_reg;
            PH_LAST:                         eval_finish = rd_bit_reg;
            default:                         eval_finish = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && (pix_idx_reg < XW'(MAX_WIDTH)))
            row_mem[pix_idx_reg[AW-1:0]] <= pixel;
        if (rd_en)
            rd_bit_reg <= row_mem[pos_reg[AW-1:0]];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SC_LOAD:
            begin
                if (accept && row_end)
                    state_next = SC_STEP;
            end
            SC_STEP:
            begin
                if (!stop_bound)
                    state_next = SC_EVAL;
                else if (phase_reg != PH_A_LEFT)
                    state_next = SC_FIN;
            end
            SC_EVAL:
            begin
                state_next = eval_finish ? SC_FIN : SC_STEP;
            end
            SC_FIN:
            begin
                if (res_ready)
                    state_next = SC_LOAD;
            end
            default: state_next = SC_LOAD;
        endcase
    end

    // datapath
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        flags_next   = flags_reg;
        pix_idx_next = pix_idx_reg;

        if (accept)
        begin
            if (row_end)
                pix_idx_next = '0;
            else if (pix_idx_reg < XW'(MAX_WIDTH))
                pix_idx_next = pix_idx_reg + 1'b1;
        end

        unique case (state_reg)
            SC_LOAD:
            begin
                if (accept && row_end)
                begin
                    phase_next           = PH_SEED;
                    pos_next             = x0;
                    left_next            = '0;
                    right_next           = '0;
                    flags_next.found     = 1'b1;
                    flags_next.hit_left  = 1'b0;
                    flags_next.hit_right = 1'b0;
                    flags_next.frame_end = frame_end;
                end
            end
            SC_STEP:
            begin
                if (stop_bound)
                begin
                    unique case (phase_reg) inside
                        PH_A_LEFT:
                        begin
                            flags_next.hit_left = 1'b1;
                            phase_next          = PH_A_RIGHT;
                            pos_next            = x0;
                        end
                        PH_A_RIGHT, PH_B_RUN:
                        begin
                            right_next           = col;
                            flags_next.hit_right = 1'b1;
                        end
                        PH_B_FIND, PH_C_FIND:
                        begin
                            flags_next.found = 1'b0;
                        end
                        PH_C_LEFT:
                        begin
                            flags_next.hit_left = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            SC_EVAL:
            begin
                unique case (phase_reg)
                    PH_SEED:
                    begin
                        phase_next = rd_bit_reg ? PH_A_LEFT : PH_ZERO;
                        pos_next   = rd_bit_reg ? x0 : '0;
                    end
                    PH_ZERO:
                    begin
                        phase_next = rd_bit_reg ? PH_LAST : PH_B_FIND;
                        pos_next   = rd_bit_reg ? col - 1'b1 : '0;
                    end
                    PH_LAST:
                    begin
                        // lane at both borders only: found with all edges at zero
                        if (!rd_bit_reg)
                        begin
                            phase_next = PH_C_FIND;
                            pos_next   = col - 1'b1;
                        end
                    end
                    PH_A_LEFT:
                    begin
                        if (!rd_bit_reg)
                        begin
                            left_next  = pos_reg;
                            phase_next = PH_A_RIGHT;
                            pos_next   = x0;
                        end
                        else
                            pos_next = pos_reg - 1'b1;
                    end
                    PH_A_RIGHT, PH_B_RUN:
                    begin
                        if (!rd_bit_reg)
                            right_next = pos_reg;
                        else
                            pos_next = pos_reg + 1'b1;
                    end
                    PH_B_FIND:
                    begin
                        if (rd_bit_reg)
                        begin
                            left_next  = pos_reg;
                            phase_next = PH_B_RUN;
                        end
                        else
                            pos_next = pos_reg + 1'b1;
                    end
                    PH_C_FIND:
                    begin
                        if (rd_bit_reg)
                        begin
                            right_next = pos_reg;
                            phase_next = PH_C_LEFT;
                        end
                        else
                            pos_next = pos_reg - 1'b1;
                    end
                    PH_C_LEFT:
                    begin
                        if (!rd_bit_reg)
                            left_next = pos_reg;
                        else
                            pos_next = pos_reg - 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= SC_LOAD;
            phase_reg   <= PH_SEED;
            pix_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            pix_idx_reg <= pix_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        flags_reg <= flags_next;
    end

    assign res_valid = (state_reg == SC_FIN);
    assign left      = left_reg;
    assign right     = right_reg;
    assign flags     = flags_reg;

endmodule

FILE: design/lbrs_frame.sv
// Frame statistics, seed column, drive mode and the result register.
// Depends on lbrs_pkg.
module lbrs_frame #(
    parameter int MAX_WIDTH = lbrs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_ROWS  = lbrs_pkg::MAX_ROWS_DEF,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int XW = AW + 1,
    localparam int CW = $clog2(MAX_ROWS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lbrs_pkg::cfg_t        cfg,
    input  logic [XW-1:0]         col,
    input  logic                  res_valid,
    output logic                  res_ready,
    input  logic [XW-1:0]         left,
    input  logic [XW-1:0]         right,
    input  lbrs_pkg::scan_flags_t flags,
    output logic [AW-1:0]         seed,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [XW-1:0]         left_x,
    output logic [XW-1:0]         right_x,
    output logic [AW-1:0]         mid_x,
    output logic                  row_found,
    output logic                  frame_done,
    output logic [1:0]            drive_mode,
    output logic                  left_is_border,
    output logic                  right_is_border,
    output logic [CW-1:0]         rows_counted
);
    import lbrs_pkg::*;

    localparam int KW = ((CW > ST_W) ? CW : ST_W) + 1;
    localparam int SEED_RST_I =
        ((IMAGE_WIDTH_RST < MAX_WIDTH) ? IMAGE_WIDTH_RST : MAX_WIDTH) / 2;
    localparam logic [AW-1:0] SEED_RST = AW'(SEED_RST_I);

    logic [AW-1:0] seed_reg, seed_next;
    logic [CW-1:0] found_cnt_reg, found_cnt_next;
    logic [CW-1:0] lhits_reg, lhits_next;
    logic [CW-1:0] rhits_reg, rhits_next;
    logic          out_valid_reg;

    logic [XW-1:0] left_x_reg, right_x_reg;
    logic [AW-1:0] mid_x_reg;
    logic          row_found_reg, frame_done_reg, lb_reg, rb_reg;
    drive_mode_t   mode_reg, mode_c;
    logic [CW-1:0] rows_reg;

    logic          take;
    logic [XW:0]   edge_sum;
    logic [AW-1:0] mid_c;
    logic [CW-1:0] fc_new, lh_new, rh_new;
    logic          below_bound;
    logic          lb_c, rb_c;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v < CW'(MAX_ROWS)) ? v + 1'b1 : v;
    endfunction

    assign res_ready = !out_valid_reg || out_ready;
    assign take      = res_valid && res_ready;

    assign edge_sum = {1'b0, left} + {1'b0, right};
    assign mid_c    = edge_sum[AW:1];

    assign fc_new = flags.found     ? sat_inc(found_cnt_reg) : found_cnt_reg;
    assign lh_new = flags.hit_left  ? sat_inc(lhits_reg)     : lhits_reg;
    assign rh_new = flags.hit_right ? sat_inc(rhits_reg)     : rhits_reg;

    // found < target - thresh, kept unsigned by moving thresh to the left side
    assign below_bound = (KW'(fc_new) + KW'(cfg.border_thresh)) < KW'(cfg.sample_target);
    assign lb_c        = KW'(lh_new) >= KW'(cfg.border_thresh);
    assign rb_c        = KW'(rh_new) >= KW'(cfg.border_thresh);

    always_comb
    begin
        if (fc_new == '0)
            mode_c = MODE_LOSE;
        else if (below_bound)
            mode_c = MODE_OBSTACLE;
        else if (lb_c || rb_c)
            mode_c = MODE_HORIZONTAL;
        else
            mode_c = MODE_FORWARD;
    end

    always_comb
    begin
        seed_next      = seed_reg;
        found_cnt_next = found_cnt_reg;
        lhits_next     = lhits_reg;
        rhits_next     = rhits_reg;
        if (take)
        begin
            if (flags.frame_end)
            begin
                found_cnt_next = '0;
                lhits_next     = '0;
                rhits_next     = '0;
                seed_next      = col[XW-1:1];
            end
            else
            begin
                found_cnt_next = fc_new;
                lhits_next     = lh_new;
                rhits_next     = rh_new;
                if (flags.found)
                    seed_next = mid_c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= SEED_RST;
            found_cnt_reg <= '0;
            lhits_reg     <= '0;
            rhits_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seed_reg      <= seed_next;
            found_cnt_reg <= found_cnt_next;
            lhits_reg     <= lhits_next;
            rhits_reg     <= rhits_next;
            if (take)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            left_x_reg     <= left;
            right_x_reg    <= right;
            mid_x_reg      <= mid_c;
            row_found_reg  <= flags.found;
            frame_done_reg <= flags.frame_end;
            rows_reg       <= fc_new;
            if (flags.frame_end)
            begin
                mode_reg <= mode_c;
                lb_reg   <= (mode_c == MODE_FORWARD || mode_c == MODE_HORIZONTAL) && lb_c;
                rb_reg   <= (mode_c == MODE_FORWARD || mode_c == MODE_HORIZONTAL) && rb_c;
            end
            else
            begin
                mode_reg <= MODE_LOSE;
                lb_reg   <= 1'b0;
                rb_reg   <= 1'b0;
            end
        end
    end

    assign seed            = seed_reg;
    assign out_valid       = out_valid_reg;
    assign left_x          = left_x_reg;
    assign right_x         = right_x_reg;
    assign mid_x           = mid_x_reg;
    assign row_found       = row_found_reg;
    assign frame_done      = frame_done_reg;
    assign drive_mode      = mode_reg;
    assign left_is_border  = lb_reg;
    assign right_is_border = rb_reg;
    assign rows_counted    = rows_reg;

endmodule

FILE: design/lbrs_checker.sv
// Port-level checks for the lane boundary row scanner, bound to the top level.
// Depends on lbrs_pkg and lane_boundary_row_scanner_top_assert.svh.
`include "lane_boundary_row_scanner_top_assert.svh"

module lbrs_checker #(
    parameter int MAX_WIDTH = lbrs_pkg::MAX_WIDTH_DEF,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int XW = AW + 1
) (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          row_end,
    input logic          out_valid,
    input logic          out_ready,
    input logic [XW-1:0] left_x,
    input logic [XW-1:0] right_x,
    input logic [AW-1:0] mid_x,
    input logic          row_found,
    input logic          frame_done,
    input logic [1:0]    drive_mode,
    input logic          left_is_border,
    input logic          right_is_border
);
    import lbrs_pkg::*;

    // a row end starts the search, so the next item must wait
    `LBRS_AST_NXT(a_row_end_blocks_input, in_valid && in_ready && row_end, !in_ready)

    `LBRS_AST_NXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(left_x) && $stable(mid_x))

    `LBRS_AST_IMP(a_empty_row_zero, out_valid && !row_found, left_x == '0 && right_x == '0 && mid_x == '0)

    // border flags only come with a forward or horizontal frame report
    `LBRS_AST_IMP(a_border_only_in_report, out_valid && (!frame_done || drive_mode == MODE_LOSE || drive_mode == MODE_OBSTACLE), !left_is_border && !right_is_border)

endmodule

bind lane_boundary_row_scanner_top lbrs_checker #(.MAX_WIDTH(MAX_WIDTH)) u_lbrs_checker (.*);
